// ----- hw/rtl/bbn_pkg.sv -----
// Shared types, constants and helper functions for the edge-normalized 3x3 box blur.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package bbn_pkg;

  // Line store depth and the fixed field widths.
  localparam int MAX_WIDTH = 256;
  localparam int SAMPLE_W  = 16;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  // The effective width is bounded by the line store depth and by the register range.
  localparam int CFG_MAX   = (1 << CFG_W) - 1;
  localparam int EFF_W_MAX = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
  localparam int COL_W     = $clog2(EFF_W_MAX + 1);
  localparam int ROW_W     = CFG_W;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);

  // Saturated samples are at most 2^15, so three of them fit in 17 bits and nine in 19.
  localparam int COLSUM_W = SAMPLE_W + 1;
  localparam int SUM_W    = SAMPLE_W + 3;

  // Division by the neighbor count is a multiply by a rounded-up reciprocal.
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_ONE  = RECIP_W'(1 << RECIP_SHIFT);
  localparam logic [RECIP_W-1:0] RECIP_FOUR = RECIP_W'(1 << (RECIP_SHIFT - 2));
  localparam logic [RECIP_W-1:0] RECIP_SIX  = RECIP_W'(((1 << RECIP_SHIFT) + 5) / 6);
  localparam logic [RECIP_W-1:0] RECIP_NINE = RECIP_W'(((1 << RECIP_SHIFT) + 8) / 9);

  localparam logic [SAMPLE_W-1:0] Q_ONE      = SAMPLE_W'(32768);
  localparam logic [CFG_W-1:0]    CFG_RESET  = CFG_W'(256);

  // Command codes and register indexes.
  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;
  localparam logic [CFG_IDX_W-1:0] IDX_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] IDX_FRAME_HEIGHT = CFG_IDX_W'(1);

  // Number of samples averaged for one result.
  typedef enum logic [1:0] {
    CNT_ONE,
    CNT_FOUR,
    CNT_SIX,
    CNT_NINE
  } count_e;

  // Which neighbors of the window center lie inside the frame.
  typedef struct packed {
    logic left;
    logic right;
    logic top;
    logic bot;
  } win_flags_t;

  // One decoded beat, handed from the controller to the line stores.
  typedef struct packed {
    logic                  emit;
    logic                  shift;
    logic                  wr;
    logic                  zero_col;
    logic                  bypass;
    logic                  last;
    win_flags_t            flags;
    logic [ADDR_W-1:0]     addr;
    logic [SAMPLE_W-1:0]   sample;
  } line_req_t;

  // What travels with a window toward the averaging pipeline.
  typedef struct packed {
    logic                last;
    logic                bypass;
    win_flags_t          flags;
    logic [SAMPLE_W-1:0] pass;
  } mean_info_t;

  // Window columns left to right, each with rows top to bottom.
  typedef logic [2:0][2:0][SAMPLE_W-1:0] window_t;

  function automatic logic [RECIP_W-1:0] recip_of(count_e cnt);
    logic [RECIP_W-1:0] r;
    unique case (cnt)
      CNT_ONE:  r = RECIP_ONE;
      CNT_FOUR: r = RECIP_FOUR;
      CNT_SIX:  r = RECIP_SIX;
      CNT_NINE: r = RECIP_NINE;
      default:  r = RECIP_ONE;
    endcase
    return r;
  endfunction

  // Half the count, added before the divide to round to nearest.
  function automatic logic [2:0] half_of(count_e cnt);
    logic [2:0] h;
    unique case (cnt)
      CNT_ONE:  h = 3'd0;
      CNT_FOUR: h = 3'd2;
      CNT_SIX:  h = 3'd3;
      CNT_NINE: h = 3'd4;
      default:  h = 3'd0;
    endcase
    return h;
  endfunction

endpackage

// ----- hw/rtl/box_blur_3x3_edge_normalized_top.sv -----
// Edge-normalized 3x3 box blur over a raster Q1.15 mask stream with two line stores.
// Throughput: one beat per cycle while in_stall_o is low; line store read at accept, written back
// as the beat leaves stage one. A result passes the window, column-sum, sum, product and output
// registers after the beat that completes its window, which trails the matching sample by one row
// plus one sample; width+1 drains flush a frame. Reset clears counters, window and pipeline and
// sets both frame sizes to 256; line store contents are not cleared.
`timescale 1ns / 1ps

module box_blur_3x3_edge_normalized_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bbn_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bbn_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [bbn_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bbn_pkg::SAMPLE_W-1:0]  blurred_o,
  output logic                          frame_last_o
);

  bbn_pkg::line_req_t  req;
  bbn_pkg::mean_info_t info;
  bbn_pkg::window_t    win;
  logic                s1_ready, s3_ready, s2_valid;

  // Beat decode and frame position.
  bbn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .sample_i    (sample_i),
    .s1_ready_i  (s1_ready),
    .req_o       (req)
  );

  // Line stores and window.
  bbn_lines u_lines (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_i      (req),
    .s1_ready_o (s1_ready),
    .s3_ready_i (s3_ready),
    .s2_valid_o (s2_valid),
    .info_o     (info),
    .win_o      (win)
  );

  // Averaging and output register.
  bbn_mean u_mean (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s2_valid_i   (s2_valid),
    .info_i       (info),
    .win_i        (win),
    .s3_ready_o   (s3_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .blurred_o    (blurred_o),
    .frame_last_o (frame_last_o)
  );

  assign in_stall_o = !s1_ready;

endmodule

// ----- hw/rtl/bbn_ctrl.sv -----
// Frame controller: configuration registers, raster counters and per-beat decode.
// Depends on bbn_pkg.
`timescale 1ns / 1ps

module bbn_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bbn_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bbn_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          command_i,
  input  logic [bbn_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                          s1_ready_i,
  output bbn_pkg::line_req_t            req_o
);

  logic [bbn_pkg::CFG_W-1:0]    width_q, height_q;
  logic [bbn_pkg::COL_W-1:0]    col_q, col_d, eff_w, w_m1;
  logic [bbn_pkg::ROW_W-1:0]    row_q, row_d, eff_h, h_m1;
  logic                         bypass, accept, cfg_hit;
  logic [bbn_pkg::SAMPLE_W-1:0] sample_sat;

  // Effective frame size: zero acts as one, width is capped by the line store depth.
  always_comb begin
    if (width_q == '0) begin
      eff_w = bbn_pkg::COL_W'(1);
    end else if (width_q > bbn_pkg::CFG_W'(bbn_pkg::EFF_W_MAX)) begin
      eff_w = bbn_pkg::COL_W'(bbn_pkg::EFF_W_MAX);
    end else begin
      eff_w = bbn_pkg::COL_W'(width_q);
    end
  end

  assign eff_h      = (height_q == '0) ? bbn_pkg::ROW_W'(1) : height_q;
  assign w_m1       = eff_w - bbn_pkg::COL_W'(1);
  assign h_m1       = eff_h - bbn_pkg::ROW_W'(1);
  assign bypass     = (eff_w < bbn_pkg::COL_W'(3)) || (eff_h < bbn_pkg::ROW_W'(3));
  assign accept     = in_valid_i && s1_ready_i;
  assign cfg_hit    = cfg_we_i && (cfg_index_i == bbn_pkg::IDX_FRAME_WIDTH ||
                                   cfg_index_i == bbn_pkg::IDX_FRAME_HEIGHT);
  assign sample_sat = (sample_i > bbn_pkg::Q_ONE) ? bbn_pkg::Q_ONE : sample_i;

  // Decode the beat against the raster position and work out the next position.
  always_comb begin
    req_o        = '0;
    req_o.addr   = bbn_pkg::ADDR_W'(col_q);
    req_o.sample = sample_sat;
    col_d        = col_q;
    row_d        = row_q;
    priority if (bypass) begin
      // Small frames pass each pushed sample straight through.
      if (command_i == bbn_pkg::CMD_PUSH) begin
        req_o.emit   = 1'b1;
        req_o.bypass = 1'b1;
        req_o.last   = (col_q == w_m1) && (row_q == h_m1);
        if (req_o.last) begin
          col_d = '0;
          row_d = '0;
        end else if (col_q == w_m1) begin
          col_d = '0;
          row_d = row_q + bbn_pkg::ROW_W'(1);
        end else begin
          col_d = col_q + bbn_pkg::COL_W'(1);
        end
      end
    end else if (row_q < eff_h) begin
      // Frame input: every push updates the line stores and the window.
      if (command_i == bbn_pkg::CMD_PUSH) begin
        req_o.shift = 1'b1;
        req_o.wr    = 1'b1;
        if (col_q == '0) begin
          // Result for the last column of the row before the previous one.
          req_o.emit        = (row_q >= bbn_pkg::ROW_W'(2));
          req_o.flags.left  = 1'b1;
          req_o.flags.right = 1'b0;
          req_o.flags.top   = (row_q >= bbn_pkg::ROW_W'(3));
          req_o.flags.bot   = 1'b1;
        end else begin
          req_o.emit        = (row_q >= bbn_pkg::ROW_W'(1));
          req_o.flags.left  = (col_q >= bbn_pkg::COL_W'(2));
          req_o.flags.right = 1'b1;
          req_o.flags.top   = (row_q >= bbn_pkg::ROW_W'(2));
          req_o.flags.bot   = 1'b1;
        end
        if (col_q == w_m1) begin
          col_d = '0;
          row_d = row_q + bbn_pkg::ROW_W'(1);
        end else begin
          col_d = col_q + bbn_pkg::COL_W'(1);
        end
      end
    end else begin
      // Drain: virtual row below the frame, one column past the right edge at the end.
      if (command_i == bbn_pkg::CMD_DRAIN) begin
        req_o.shift    = 1'b1;
        req_o.emit     = 1'b1;
        req_o.zero_col = (col_q == eff_w);
        req_o.last     = (col_q == eff_w);
        if (col_q == '0) begin
          req_o.flags.left  = 1'b1;
          req_o.flags.right = 1'b0;
          req_o.flags.top   = 1'b1;
          req_o.flags.bot   = 1'b1;
        end else begin
          req_o.flags.left  = (col_q >= bbn_pkg::COL_W'(2));
          req_o.flags.right = (col_q != eff_w);
          req_o.flags.top   = 1'b1;
          req_o.flags.bot   = 1'b0;
        end
        if (req_o.last) begin
          col_d = '0;
          row_d = '0;
        end else begin
          col_d = col_q + bbn_pkg::COL_W'(1);
        end
      end
    end
  end

  // Registers and counters; any register write restarts the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bbn_pkg::CFG_RESET;
      height_q <= bbn_pkg::CFG_RESET;
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_hit) begin
      if (cfg_index_i == bbn_pkg::IDX_FRAME_WIDTH) begin
        width_q <= cfg_wdata_i;
      end else begin
        height_q <= cfg_wdata_i;
      end
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // The raster position never runs past the frame it belongs to.
  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= eff_w) && (row_q <= eff_h))
    else $error("raster position outside the frame");

endmodule

// ----- hw/rtl/bbn_lines.sv -----
// Line stores and the 3x3 window: read at accept, write back and shift as the beat leaves stage one.
// Depends on bbn_pkg.
`timescale 1ns / 1ps

module bbn_lines (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  bbn_pkg::line_req_t  req_i,
  output logic                s1_ready_o,
  input  logic                s3_ready_i,
  output logic                s2_valid_o,
  output bbn_pkg::mean_info_t info_o,
  output bbn_pkg::window_t    win_o
);

  logic [bbn_pkg::SAMPLE_W-1:0] older_mem [bbn_pkg::MAX_WIDTH];
  logic [bbn_pkg::SAMPLE_W-1:0] newer_mem [bbn_pkg::MAX_WIDTH];
  logic [bbn_pkg::SAMPLE_W-1:0] older_rd_q, newer_rd_q;
  logic [bbn_pkg::SAMPLE_W-1:0] col_top, col_mid, col_bot;
  bbn_pkg::line_req_t           s1_q;
  bbn_pkg::mean_info_t          s2_info_q;
  bbn_pkg::window_t             win_q;
  logic                         s1_v_q, s2_v_q;
  logic                         s1_ready, s2_ready, rd_en, wr_en;

  // Stage handshake: the window is stage-two payload, so stage one waits on stage two.
  assign s2_ready   = !s2_v_q || s3_ready_i;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign s1_ready_o = s1_ready;
  assign rd_en      = in_valid_i && s1_ready && req_i.shift && !req_i.zero_col;
  assign wr_en      = s1_v_q && s2_ready && s1_q.wr;

  // Both stores: read the column at accept, write it back when the beat leaves stage one.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      older_rd_q <= older_mem[req_i.addr];
      newer_rd_q <= newer_mem[req_i.addr];
    end
    if (wr_en) begin
      older_mem[s1_q.addr] <= newer_rd_q;
      newer_mem[s1_q.addr] <= s1_q.sample;
    end
  end

  // New window column: stored rows on top, the pushed sample (zero on drain) at the bottom.
  assign col_top = s1_q.zero_col ? '0 : older_rd_q;
  assign col_mid = s1_q.zero_col ? '0 : newer_rd_q;
  assign col_bot = s1_q.wr ? s1_q.sample : '0;

  // Stage one payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_q <= req_i;
    end
  end

  // Stage valids and the window shift.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      win_q  <= '0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= in_valid_i && (req_i.emit || req_i.shift);
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q && s1_q.emit;
      end
      if (s1_v_q && s2_ready && s1_q.shift) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= {col_bot, col_mid, col_top};
      end
    end
  end

  // Stage two payload.
  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_v_q) begin
      s2_info_q.last   <= s1_q.last;
      s2_info_q.bypass <= s1_q.bypass;
      s2_info_q.flags  <= s1_q.flags;
      s2_info_q.pass   <= s1_q.sample;
    end
  end

  assign s2_valid_o = s2_v_q;
  assign info_o     = s2_info_q;
  assign win_o      = win_q;

  // A column is never read in the same cycle it is written back.
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && wr_en) |-> (req_i.addr != s1_q.addr))
    else $error("line store read and write hit the same column");

  // The window does not move while its result waits for the averaging pipeline.
  a_window_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && !s2_ready) |=> $stable(win_q))
    else $error("window shifted under a waiting result");

endmodule

// ----- hw/rtl/bbn_mean.sv -----
// Averaging pipeline: masked column sums, rounding offset, reciprocal multiply, output beat.
// Depends on bbn_pkg.
`timescale 1ns / 1ps

module bbn_mean (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s2_valid_i,
  input  bbn_pkg::mean_info_t          info_i,
  input  bbn_pkg::window_t             win_i,
  output logic                         s3_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bbn_pkg::SAMPLE_W-1:0] blurred_o,
  output logic                         frame_last_o
);

  logic [2:0][bbn_pkg::COLSUM_W-1:0] colsum, colsum_q;
  bbn_pkg::mean_info_t               info3_q;
  bbn_pkg::count_e                   cnt;
  logic [bbn_pkg::SUM_W-1:0]         n_d, n_q;
  logic [bbn_pkg::RECIP_W-1:0]       recip_q;
  logic [bbn_pkg::PROD_W-1:0]        prod_q;
  logic [bbn_pkg::SAMPLE_W-1:0]      blurred_q;
  logic                              last4_q, last5_q, last_out_q;
  logic                              s3_v_q, s4_v_q, s5_v_q, out_v_q;
  logic                              s3_ready, s4_ready, s5_ready, out_ready;

  // Each stage takes a beat when it is empty or its beat moves on.
  assign out_ready  = !out_v_q || !out_stall_i;
  assign s5_ready   = !s5_v_q || out_ready;
  assign s4_ready   = !s4_v_q || s5_ready;
  assign s3_ready   = !s3_v_q || s4_ready;
  assign s3_ready_o = s3_ready;

  // Column sums over the rows that lie inside the frame.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      colsum[k] = bbn_pkg::COLSUM_W'(win_i[k][1])
                + (info_i.flags.top ? bbn_pkg::COLSUM_W'(win_i[k][0]) : '0)
                + (info_i.flags.bot ? bbn_pkg::COLSUM_W'(win_i[k][2]) : '0);
    end
  end

  // Neighbor count from the edge flags.
  always_comb begin
    priority if (info3_q.bypass) begin
      cnt = bbn_pkg::CNT_ONE;
    end else if ((info3_q.flags.left && info3_q.flags.right) &&
                 (info3_q.flags.top && info3_q.flags.bot)) begin
      cnt = bbn_pkg::CNT_NINE;
    end else if ((info3_q.flags.left && info3_q.flags.right) ||
                 (info3_q.flags.top && info3_q.flags.bot)) begin
      cnt = bbn_pkg::CNT_SIX;
    end else begin
      cnt = bbn_pkg::CNT_FOUR;
    end
  end

  // Window sum plus half the count; a pass-through sample goes in unchanged.
  assign n_d = info3_q.bypass ? bbn_pkg::SUM_W'(info3_q.pass)
             : bbn_pkg::SUM_W'(colsum_q[1])
             + (info3_q.flags.left  ? bbn_pkg::SUM_W'(colsum_q[0]) : '0)
             + (info3_q.flags.right ? bbn_pkg::SUM_W'(colsum_q[2]) : '0)
             + bbn_pkg::SUM_W'(bbn_pkg::half_of(cnt));

  // Stage valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_v_q <= s2_valid_i;
      end
      if (s4_ready) begin
        s4_v_q <= s3_v_q;
      end
      if (s5_ready) begin
        s5_v_q <= s4_v_q;
      end
      if (out_ready) begin
        out_v_q <= s5_v_q;
      end
    end
  end

  // Payload: sums, then the reciprocal product, then the quotient in the output register.
  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_i) begin
      colsum_q <= colsum;
      info3_q  <= info_i;
    end
    if (s4_ready && s3_v_q) begin
      n_q     <= n_d;
      recip_q <= bbn_pkg::recip_of(cnt);
      last4_q <= info3_q.last;
    end
    if (s5_ready && s4_v_q) begin
      prod_q  <= bbn_pkg::PROD_W'(n_q) * bbn_pkg::PROD_W'(recip_q);
      last5_q <= last4_q;
    end
    if (out_ready && s5_v_q) begin
      blurred_q  <= prod_q[bbn_pkg::RECIP_SHIFT +: bbn_pkg::SAMPLE_W];
      last_out_q <= last5_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign blurred_o    = blurred_q;
  assign frame_last_o = last_out_q;

  // The quotient fits the output field and never exceeds one.
  a_mean_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s5_v_q |-> ((prod_q >> bbn_pkg::RECIP_SHIFT) <= bbn_pkg::PROD_W'(bbn_pkg::Q_ONE)))
    else $error("averaged value out of range");

endmodule
